// File: hw/rtl/assert_macros.svh
// Assertion helper macros for the text console writer.
// Expects signals named clk and rst_n in the including module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock while out of reset.
`define TCW_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error("tcw check failed");

// Expression must never be true while out of reset.
`define TCW_NEVER(lbl, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error("tcw forbidden condition");

`endif

// File: hw/rtl/tcw_pkg.sv
// Shared types and constants for the text console writer.
// No dependencies.
`default_nettype none

package tcw_pkg;

  localparam int COLUMNS_DEF = 80;
  localparam int ROWS_DEF    = 25;

  localparam logic [7:0] ATTR_RESET = 8'h05;

  typedef enum logic [2:0] {
    CMD_PUT_CHAR   = 3'd0,
    CMD_NEW_LINE   = 3'd1,
    CMD_CLEAR      = 3'd2,
    CMD_SET_CURSOR = 3'd3,
    CMD_READ_CELL  = 3'd4
  } cmd_t;

  typedef enum logic [3:0] {
    ST_INIT,
    ST_IDLE,
    ST_DECODE,
    ST_SCROLL,
    ST_CLEAR,
    ST_ADDR,
    ST_WRITE,
    ST_READ,
    ST_RWAIT,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic [15:0] cell_value;
    logic [6:0]  cursor_col;
    logic [4:0]  cursor_row;
    logic        scrolled;
  } res_t;

endpackage

`default_nettype wire

// File: hw/rtl/tcw_if.sv
// Valid/ready channel interfaces for the text console writer.
// Standalone; field widths are fixed by the command format.
`default_nettype none

interface tcw_in_if;
  logic       valid;
  logic       ready;
  logic [2:0] cmd;
  logic [7:0] char_code;
  logic [6:0] cell_col;
  logic [4:0] cell_row;

  modport source (output valid, cmd, char_code, cell_col, cell_row, input ready);
  modport sink   (input valid, cmd, char_code, cell_col, cell_row, output ready);
endinterface

interface tcw_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] cell_value;
  logic [6:0]  cursor_col;
  logic [4:0]  cursor_row;
  logic        scrolled;

  modport source (output valid, cell_value, cursor_col, cursor_row, scrolled, input ready);
  modport sink   (input valid, cell_value, cursor_col, cursor_row, scrolled, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/tcw_screen_mem.sv
// Single-port screen cell memory with registered read data.
// No dependencies.
`default_nettype none

module tcw_screen_mem #(
  parameter int DEPTH = 2000,
  parameter int AW    = 11
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] addr,
  input  wire logic [15:0]   wdata,
  output logic      [15:0]   rdata
);

  logic [15:0] mem [DEPTH];
  logic [15:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata_r <= mem[addr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// File: hw/rtl/tcw_seq.sv
// Command sequencer: cursor, row offset, shared address unit, sweeps.
// Depends on tcw_pkg, tcw_if and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module tcw_seq #(
  parameter int COLUMNS = tcw_pkg::COLUMNS_DEF,
  parameter int ROWS    = tcw_pkg::ROWS_DEF,
  parameter int AW      = $clog2(COLUMNS * ROWS)
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  tcw_in_if.sink             in_ch,
  input  wire logic [7:0]    attr,
  output logic               res_valid,
  input  wire logic          res_ready,
  output tcw_pkg::res_t      res,
  output logic               mem_we,
  output logic      [AW-1:0] mem_addr,
  output logic      [15:0]   mem_wdata,
  input  wire logic [15:0]   mem_rdata
);

  localparam int CELLS = COLUMNS * ROWS;
  localparam int CW    = $clog2(COLUMNS + 1);
  localparam int RW    = $clog2(ROWS + 2);
  localparam int TW    = $clog2(ROWS);

  tcw_pkg::state_t state_r, state_nxt;
  logic [2:0]    cmd_r, cmd_nxt;
  logic [7:0]    char_r, char_nxt;
  logic [6:0]    col_in_r, col_in_nxt;
  logic [4:0]    row_in_r, row_in_nxt;
  logic [CW-1:0] ccol_r, ccol_nxt;
  logic [RW-1:0] crow_r, crow_nxt;
  logic [TW-1:0] top_r, top_nxt;
  logic [AW-1:0] base_r, base_nxt;
  logic [AW-1:0] idx_r, idx_nxt;
  logic          scrolled_r, scrolled_nxt;
  logic [15:0]   value_r, value_nxt;

  // shared row mapper: logical row -> physical row base address
  logic [TW-1:0] row_sel;
  logic [TW:0]   row_sum;
  logic [TW-1:0] phys_row;
  logic [AW-1:0] row_base;
  logic [TW-1:0] top_inc;
  logic          wrap;
  logic [RW-1:0] row_w;
  logic          in_range;

  always_comb begin
    row_sel = '0;
    if (state_r == tcw_pkg::ST_ADDR) begin
      row_sel = TW'(crow_r);
    end else if (cmd_r == tcw_pkg::CMD_READ_CELL) begin
      row_sel = TW'(row_in_r);
    end
  end

  assign row_sum  = {1'b0, row_sel} + {1'b0, top_r};
  assign phys_row = (32'(row_sum) >= ROWS) ? TW'(32'(row_sum) - ROWS) : TW'(row_sum);
  assign row_base = AW'(32'(phys_row) * COLUMNS);
  assign top_inc  = (32'(top_r) == ROWS - 1) ? '0 : top_r + 1'b1;

  assign wrap     = (32'(ccol_r) >= COLUMNS);
  assign row_w    = wrap ? crow_r + 1'b1 : crow_r;
  assign in_range = (32'(col_in_r) < COLUMNS) && (32'(row_in_r) < ROWS);

  assign mem_addr = base_r + idx_r;

  always_comb begin
    state_nxt    = state_r;
    cmd_nxt      = cmd_r;
    char_nxt     = char_r;
    col_in_nxt   = col_in_r;
    row_in_nxt   = row_in_r;
    ccol_nxt     = ccol_r;
    crow_nxt     = crow_r;
    top_nxt      = top_r;
    base_nxt     = base_r;
    idx_nxt      = idx_r;
    scrolled_nxt = scrolled_r;
    value_nxt    = value_r;
    in_ch.ready  = 1'b0;
    res_valid    = 1'b0;
    mem_we       = 1'b0;
    mem_wdata    = '0;

    case (state_r)
      tcw_pkg::ST_INIT, tcw_pkg::ST_CLEAR: begin
        mem_we  = 1'b1;
        idx_nxt = idx_r + 1'b1;
        if (32'(idx_r) == CELLS - 1) begin
          state_nxt = (state_r == tcw_pkg::ST_INIT) ? tcw_pkg::ST_IDLE : tcw_pkg::ST_DONE;
        end
      end
      tcw_pkg::ST_IDLE: begin
        in_ch.ready = 1'b1;
        if (in_ch.valid) begin
          cmd_nxt      = in_ch.cmd;
          char_nxt     = in_ch.char_code;
          col_in_nxt   = in_ch.cell_col;
          row_in_nxt   = in_ch.cell_row;
          scrolled_nxt = 1'b0;
          value_nxt    = '0;
          state_nxt    = tcw_pkg::ST_DECODE;
        end
      end
      tcw_pkg::ST_DECODE: begin
        state_nxt = tcw_pkg::ST_DONE;
        case (cmd_r)
          tcw_pkg::CMD_PUT_CHAR: begin
            if (32'(row_w) >= ROWS) begin
              // scroll: old top row becomes the blank bottom row
              ccol_nxt     = '0;
              crow_nxt     = RW'(ROWS - 1);
              scrolled_nxt = 1'b1;
              base_nxt     = row_base;
              idx_nxt      = '0;
              top_nxt      = top_inc;
              state_nxt    = tcw_pkg::ST_SCROLL;
            end else begin
              ccol_nxt  = wrap ? '0 : ccol_r;
              crow_nxt  = row_w;
              state_nxt = tcw_pkg::ST_ADDR;
            end
          end
          tcw_pkg::CMD_NEW_LINE: begin
            ccol_nxt = '0;
            if (32'(crow_r) >= ROWS) begin
              crow_nxt     = RW'(ROWS);
              scrolled_nxt = 1'b1;
              base_nxt     = row_base;
              idx_nxt      = '0;
              top_nxt      = top_inc;
              state_nxt    = tcw_pkg::ST_SCROLL;
            end else begin
              crow_nxt = crow_r + 1'b1;
            end
          end
          tcw_pkg::CMD_CLEAR: begin
            ccol_nxt  = '0;
            crow_nxt  = '0;
            top_nxt   = '0;
            base_nxt  = '0;
            idx_nxt   = '0;
            state_nxt = tcw_pkg::ST_CLEAR;
          end
          tcw_pkg::CMD_SET_CURSOR: begin
            ccol_nxt = (32'(col_in_r) > COLUMNS) ? CW'(COLUMNS) : CW'(col_in_r);
            crow_nxt = (32'(row_in_r) > ROWS) ? RW'(ROWS) : RW'(row_in_r);
          end
          tcw_pkg::CMD_READ_CELL: begin
            if (in_range) begin
              base_nxt  = row_base;
              idx_nxt   = AW'(col_in_r);
              state_nxt = tcw_pkg::ST_READ;
            end
          end
          default: begin
            state_nxt = tcw_pkg::ST_DONE;
          end
        endcase
      end
      tcw_pkg::ST_SCROLL: begin
        mem_we  = 1'b1;
        idx_nxt = idx_r + 1'b1;
        if (32'(idx_r) == COLUMNS - 1) begin
          state_nxt = (cmd_r == tcw_pkg::CMD_PUT_CHAR) ? tcw_pkg::ST_ADDR : tcw_pkg::ST_DONE;
        end
      end
      tcw_pkg::ST_ADDR: begin
        base_nxt  = row_base;
        idx_nxt   = AW'(ccol_r);
        state_nxt = tcw_pkg::ST_WRITE;
      end
      tcw_pkg::ST_WRITE: begin
        mem_we    = 1'b1;
        mem_wdata = {attr, char_r};
        ccol_nxt  = ccol_r + 1'b1;
        state_nxt = tcw_pkg::ST_DONE;
      end
      tcw_pkg::ST_READ: begin
        state_nxt = tcw_pkg::ST_RWAIT;
      end
      tcw_pkg::ST_RWAIT: begin
        value_nxt = mem_rdata;
        state_nxt = tcw_pkg::ST_DONE;
      end
      tcw_pkg::ST_DONE: begin
        res_valid = 1'b1;
        if (res_ready) begin
          state_nxt = tcw_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = tcw_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= tcw_pkg::ST_INIT;
      ccol_r     <= '0;
      crow_r     <= '0;
      top_r      <= '0;
      base_r     <= '0;
      idx_r      <= '0;
      scrolled_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      ccol_r     <= ccol_nxt;
      crow_r     <= crow_nxt;
      top_r      <= top_nxt;
      base_r     <= base_nxt;
      idx_r      <= idx_nxt;
      scrolled_r <= scrolled_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r    <= cmd_nxt;
    char_r   <= char_nxt;
    col_in_r <= col_in_nxt;
    row_in_r <= row_in_nxt;
    value_r  <= value_nxt;
  end

  assign res.cell_value = value_r;
  assign res.cursor_col = 7'(ccol_r);
  assign res.cursor_row = 5'(crow_r);
  assign res.scrolled   = scrolled_r;

  // cursor never beyond a pending wrap/scroll between commands
  `TCW_ASSERT(a_cursor_bound, (state_r == tcw_pkg::ST_IDLE) |-> (32'(ccol_r) <= COLUMNS && 32'(crow_r) <= ROWS))
  `TCW_NEVER(a_top_range, 32'(top_r) >= ROWS)
  `TCW_ASSERT(a_done_holds, (state_r == tcw_pkg::ST_DONE && !res_ready) |=> (state_r == tcw_pkg::ST_DONE))
  `TCW_ASSERT(a_scroll_in_row, (state_r == tcw_pkg::ST_SCROLL) |-> (32'(idx_r) < COLUMNS))

endmodule

`default_nettype wire

// File: hw/rtl/text_console_writer.sv
// Text console writer: put_char runs decode, address and write, plus a sweep blanking
// one row, one cell per cycle, when it scrolls; new_line runs decode, plus the sweep on
// scroll; set_cursor, unused codes and out-of-range read_cell only decode; read_cell
// runs decode, read and read-wait; clear sweeps all COLUMNS*ROWS cells. One transaction
// is in work at a time (single memory port); the next is taken the cycle after the
// result is queued. Reset (sync, active low) clears all cells with in_ch.ready low.
`default_nettype none

module text_console_writer #(
  parameter int COLUMNS = tcw_pkg::COLUMNS_DEF,
  parameter int ROWS    = tcw_pkg::ROWS_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       cfg_we,
  input  wire logic [7:0] cfg_wdata,
  tcw_in_if.sink          in_ch,
  tcw_out_if.source       out_ch
);

  localparam int CELLS = COLUMNS * ROWS;
  localparam int AW    = $clog2(CELLS);

  // attribute register: the user must write it only while idle; the block does not enforce it
  logic [7:0] attr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      attr_r <= tcw_pkg::ATTR_RESET;
    end else if (cfg_we) begin
      attr_r <= cfg_wdata;
    end
  end

  logic          mem_we;
  logic [AW-1:0] mem_addr;
  logic [15:0]   mem_wdata;
  logic [15:0]   mem_rdata;

  // screen is a ring of rows; the sequencer keeps the top-row offset
  tcw_screen_mem #(
    .DEPTH (CELLS),
    .AW    (AW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .addr  (mem_addr),
    .wdata (mem_wdata),
    .rdata (mem_rdata)
  );

  logic          res_valid;
  logic          res_ready;
  tcw_pkg::res_t res;

  tcw_seq #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS),
    .AW      (AW)
  ) u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .attr      (attr_r),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .mem_we    (mem_we),
    .mem_addr  (mem_addr),
    .mem_wdata (mem_wdata),
    .mem_rdata (mem_rdata)
  );

  // output register: frees the sequencer while the sink stalls
  logic          out_valid_r, out_valid_nxt;
  tcw_pkg::res_t out_r;

  assign res_ready = !out_valid_r || out_ch.ready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (res_valid && res_ready) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_r <= res;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.cell_value = out_r.cell_value;
  assign out_ch.cursor_col = out_r.cursor_col;
  assign out_ch.cursor_row = out_r.cursor_row;
  assign out_ch.scrolled   = out_r.scrolled;

endmodule

`default_nettype wire
